>>> rtl/demand_paging_lru_mmu_defines.svh
// assertion helpers for the paging unit
`ifndef DEMAND_PAGING_LRU_MMU_DEFINES_SVH
`define DEMAND_PAGING_LRU_MMU_DEFINES_SVH
// assert an implication with reset disable
`define DPL_ASSERT_IMP(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("lbl failed");
// assert a next-cycle implication
`define DPL_ASSERT_NXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("lbl failed");
`endif

>>> rtl/dplm_pkg.sv
`default_nettype none
package dplm_pkg;
  typedef enum logic [1:0] {
    CMD_ACCESS = 2'd0,
    CMD_TERM   = 2'd1,
    CMD_LIMIT  = 2'd2,
    CMD_BAD    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_FAULT    = 3'd1,
    ST_BAD_PAGE = 3'd2,
    ST_BAD_PROC = 3'd3,
    ST_NO_VICT  = 3'd4,
    ST_TERM     = 3'd5,
    ST_LIMIT    = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    CFG_NPROC  = 2'd0,
    CFG_NPAGES = 2'd1,
    CFG_NFRAME = 2'd2
  } cfg_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_LOOK_EVAL,
    S_FREE_RD,
    S_FREE_EVAL,
    S_LRU_RD,
    S_LRU_WAIT,
    S_LRU_EVAL,
    S_VICT_RD,
    S_VICT_WAIT,
    S_MAP,
    S_TERM_RD,
    S_TERM_WAIT,
    S_TERM_EVAL,
    S_DONE
  } state_e;

  // compare request to the oldest-stamp unit
  typedef struct packed {
    logic        load;
    logic        cand_ok;
    logic [31:0] cand;
  } cmp_req_t;

  typedef struct packed {
    logic        have;
    logic [31:0] best;
  } cmp_rsp_t;
endpackage
`default_nettype wire

>>> rtl/dplm_ram.sv
`default_nettype none
module dplm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/dplm_cmp.sv
`default_nettype none
// unsigned min unit: tracks the oldest stamp seen so far
module dplm_cmp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dplm_pkg::cmp_req_t req_i,
  output logic                    take_o,
  output dplm_pkg::cmp_rsp_t      rsp_o
);
  import dplm_pkg::*;

  logic        have_q, have_d;
  logic [31:0] best_q, best_d;

  always_comb begin
    take_o = req_i.cand_ok && (!have_q || (req_i.cand < best_q));
    have_d = have_q;
    best_d = best_q;
    if (req_i.load) begin
      have_d = 1'b0;
    end else if (take_o) begin
      have_d = 1'b1;
      best_d = req_i.cand;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else begin
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) best_q <= best_d;

  assign rsp_o = '{have: have_q, best: best_q};
endmodule
`default_nettype wire

>>> rtl/demand_paging_lru_mmu.sv
// a bad slot, bad page, unknown command or limit goes straight to the result beat; a hit, a miss
// (taking the lowest free frame, else the lru victim of its slot) and a terminate run the sequencer
// one command at a time; next start is accepted the cycle after the result beat
// the beat lasts one cycle; reset: clearing pass with busy high, then all frames free,
// no page mapped, counters and limits zero, registers at max
`default_nettype none
module demand_paging_lru_mmu #(
  parameter int MaxProcs  = 16,
  parameter int MaxPages  = 64,
  parameter int MaxFrames = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] command_i,
  input  wire logic [3:0] process_slot_i,
  input  wire logic [6:0] page_number_i,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [6:0] cfg_data_i,
  output logic            valid_o,
  output logic [2:0]      status_o,
  output logic [5:0]      frame_number_o,
  output logic [15:0]     process_faults_o,
  output logic            all_terminated_o
);
  import dplm_pkg::*;

  localparam int Entries  = MaxProcs * MaxPages;
  localparam int ClearLen = (Entries > MaxFrames) ? Entries : MaxFrames;
  localparam int EW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int FW = (MaxFrames > 1) ? $clog2(MaxFrames) : 1;
  localparam int PW = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;

  // configuration registers, raw as written
  logic [4:0] nproc_raw_q;
  logic [6:0] npages_raw_q, nframes_raw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nproc_raw_q   <= 5'd16;
      npages_raw_q  <= 7'd64;
      nframes_raw_q <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NPROC:  nproc_raw_q   <= cfg_data_i[4:0];
        CFG_NPAGES: npages_raw_q  <= cfg_data_i;
        CFG_NFRAME: nframes_raw_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp: zero acts as one, above the maximum acts as the maximum
  logic [10:0] nproc, npages, nframes;
  always_comb begin
    nproc   = (nproc_raw_q == 5'd0) ? 11'd1 :
              ({6'd0, nproc_raw_q} > 11'(MaxProcs)) ? 11'(MaxProcs) : {6'd0, nproc_raw_q};
    npages  = (npages_raw_q == 7'd0) ? 11'd1 :
              ({4'd0, npages_raw_q} > 11'(MaxPages)) ? 11'(MaxPages) : {4'd0, npages_raw_q};
    nframes = (nframes_raw_q == 7'd0) ? 11'd1 :
              ({4'd0, nframes_raw_q} > 11'(MaxFrames)) ? 11'(MaxFrames)
                                                       : {4'd0, nframes_raw_q};
  end

  // small per-slot state in flip-flops
  logic [15:0]          faults_q [MaxProcs];
  logic [6:0]           limit_q  [MaxProcs];
  logic [31:0]          use_clock_q;
  logic [4:0]           term_cnt_q;

  // command latch
  state_e        state_q, state_d;
  logic [PW-1:0] slot_q;
  logic [EW-1:0] base_q, ent_q;
  logic [10:0]   idx_q, idx_d;
  logic [EW-1:0] best_q;
  logic [5:0]    frame_q;
  logic [2:0]    status_q;

  // entry ram holds {valid, frame}, stamp ram the last use, free ram one bit per frame
  logic          ent_we, st_we, free_we;
  logic [EW-1:0] ent_waddr, raddr;
  logic [6:0]    ent_wdata, ent_rdata;
  logic [31:0]   st_rdata;
  logic [FW-1:0] free_waddr, free_raddr;
  logic          free_wdata, free_rdata;
  logic          ent_ok;
  logic [5:0]    ent_frame;

  assign ent_ok    = ent_rdata[6];
  assign ent_frame = ent_rdata[5:0];

  dplm_ram #(.Width(7), .Depth(Entries)) u_entry_ram (
    .clk_i, .we_i(ent_we), .waddr_i(ent_waddr), .wdata_i(ent_wdata),
    .raddr_i(raddr), .rdata_o(ent_rdata)
  );
  dplm_ram #(.Width(32), .Depth(Entries)) u_stamp_ram (
    .clk_i, .we_i(st_we), .waddr_i(ent_q), .wdata_i(use_clock_q),
    .raddr_i(raddr), .rdata_o(st_rdata)
  );
  dplm_ram #(.Width(1), .Depth(MaxFrames)) u_free_ram (
    .clk_i, .we_i(free_we), .waddr_i(free_waddr), .wdata_i(free_wdata),
    .raddr_i(free_raddr), .rdata_o(free_rdata)
  );

  // oldest-stamp unit for the lru scan
  cmp_req_t cmp_req;
  cmp_rsp_t cmp_rsp;
  logic     cmp_take;
  dplm_cmp u_cmp (.clk_i, .rst_ni, .req_i(cmp_req), .take_o(cmp_take), .rsp_o(cmp_rsp));

  logic [EW-1:0] cur_ent;
  assign cur_ent = base_q + EW'(idx_q);

  // free map is scanned one frame per read
  assign free_raddr = FW'(idx_q);

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  logic [3:0] in_slot;
  assign in_slot = process_slot_i;

  // base address: slot * pages, one multiply at accept
  logic [EW-1:0] in_base;
  assign in_base = EW'(32'(in_slot) * 32'(npages));

  logic slot_bad, page_bad;
  assign slot_bad = ({7'd0, in_slot} >= nproc);
  assign page_bad = (page_number_i >= limit_q[PW'(in_slot)]) ||
                    ({4'd0, page_number_i} >= npages);

  // sequencer
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    ent_we     = 1'b0;
    ent_waddr  = ent_q;
    ent_wdata  = {1'b1, frame_q};
    st_we      = 1'b0;
    free_we    = 1'b0;
    free_waddr = FW'(idx_q);
    free_wdata = 1'b0;
    raddr      = ent_q;
    cmp_req    = '{load: 1'b0, cand_ok: 1'b0, cand: st_rdata};
    unique case (state_q)
      // after reset: unmap every entry and free every frame
      S_CLEAR: begin
        ent_we     = (idx_q < 11'(Entries));
        ent_waddr  = EW'(idx_q);
        ent_wdata  = '0;
        free_we    = (idx_q < 11'(MaxFrames));
        free_wdata = 1'b1;
        if (idx_q == 11'(ClearLen - 1)) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 11'd1;
        end
      end
      S_IDLE:   ;
      S_LOOKUP: state_d = S_LOOK_EVAL;
      S_LOOK_EVAL: begin
        if (ent_ok) begin
          st_we   = 1'b1;
          state_d = S_DONE;
        end else begin
          idx_d   = '0;
          state_d = S_FREE_RD;
        end
      end
      S_FREE_RD: begin
        if (idx_q >= nframes) begin
          idx_d   = '0;
          cmp_req.load = 1'b1;
          state_d = S_LRU_RD;
        end else begin
          state_d = S_FREE_EVAL;
        end
      end
      S_FREE_EVAL: begin
        if (free_rdata) begin
          free_we = 1'b1;
          state_d = S_MAP;
        end else begin
          idx_d   = idx_q + 11'd1;
          state_d = S_FREE_RD;
        end
      end
      S_LRU_RD: begin
        raddr = cur_ent;
        if (idx_q >= npages) state_d = S_VICT_RD;
        else state_d = S_LRU_WAIT;
      end
      S_LRU_WAIT: begin
        raddr   = cur_ent;
        state_d = S_LRU_EVAL;
      end
      S_LRU_EVAL: begin
        cmp_req.cand_ok = ent_ok;
        idx_d   = idx_q + 11'd1;
        state_d = S_LRU_RD;
      end
      S_VICT_RD: begin
        raddr   = best_q;
        state_d = cmp_rsp.have ? S_VICT_WAIT : S_DONE;
      end
      S_VICT_WAIT: begin
        raddr     = best_q;
        ent_we    = 1'b1;
        ent_waddr = best_q;
        ent_wdata = '0;
        state_d   = S_MAP;
      end
      S_MAP: begin
        ent_we  = 1'b1;
        st_we   = 1'b1;
        state_d = S_DONE;
      end
      S_TERM_RD: begin
        raddr = cur_ent;
        if (idx_q >= npages) state_d = S_DONE;
        else state_d = S_TERM_WAIT;
      end
      S_TERM_WAIT: begin
        raddr   = cur_ent;
        state_d = S_TERM_EVAL;
      end
      S_TERM_EVAL: begin
        if (ent_ok) begin
          ent_we    = 1'b1;
          ent_waddr = cur_ent;
          ent_wdata = '0;
          if ({5'd0, ent_frame} < 11'(MaxFrames)) begin
            free_we    = 1'b1;
            free_waddr = FW'(ent_frame);
            free_wdata = 1'b1;
          end
        end
        idx_d   = idx_q + 11'd1;
        state_d = S_TERM_RD;
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (accept) begin
      idx_d = '0;
      if (slot_bad || command_i == CMD_LIMIT || command_i == CMD_BAD) begin
        state_d = S_DONE;
      end else if (command_i == CMD_TERM) begin
        state_d = S_TERM_RD;
      end else if (page_bad) begin
        state_d = S_DONE;
      end else begin
        state_d = S_LOOKUP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      use_clock_q  <= '0;
      term_cnt_q   <= '0;
      idx_q        <= '0;
      for (int p = 0; p < MaxProcs; p++) begin
        faults_q[p] <= '0;
        limit_q[p]  <= '0;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (accept && !slot_bad) begin
        if (command_i == CMD_LIMIT) limit_q[PW'(in_slot)] <= page_number_i;
        if (command_i == CMD_TERM && term_cnt_q != 5'd31) term_cnt_q <= term_cnt_q + 5'd1;
      end
      // a miss counts a fault whether or not a frame is found
      if (state_q == S_LOOK_EVAL && !ent_ok && faults_q[slot_q] != 16'hffff)
        faults_q[slot_q] <= faults_q[slot_q] + 16'd1;
      if ((state_q == S_LOOK_EVAL && ent_ok) || state_q == S_MAP)
        use_clock_q <= use_clock_q + 32'd1;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q  <= PW'(in_slot);
      base_q  <= in_base;
      ent_q   <= in_base + EW'(page_number_i);
      frame_q <= '0;
      if (slot_bad) status_q <= ST_BAD_PROC;
      else if (command_i == CMD_TERM) status_q <= ST_TERM;
      else if (command_i == CMD_LIMIT) status_q <= ST_LIMIT;
      else if (command_i == CMD_BAD || page_bad) status_q <= ST_BAD_PAGE;
      else status_q <= ST_HIT;
    end
    if (state_q == S_LOOK_EVAL) begin
      if (ent_ok) frame_q <= ent_frame;
      else status_q <= ST_FAULT;
    end
    if (state_q == S_FREE_EVAL && free_rdata) frame_q <= 6'(idx_q);
    if (state_q == S_LRU_EVAL && cmp_take) best_q <= cur_ent;
    if (state_q == S_VICT_WAIT) frame_q <= ent_frame;
    if (state_q == S_VICT_RD && !cmp_rsp.have) status_q <= ST_NO_VICT;
  end

  // result beat, one cycle
  logic slot_ok;
  assign slot_ok = (status_q != ST_BAD_PROC);
  assign valid_o          = (state_q == S_DONE);
  assign status_o         = status_q;
  assign frame_number_o   = (status_q == ST_HIT || status_q == ST_FAULT) ? frame_q : 6'd0;
  assign process_faults_o = slot_ok ? faults_q[slot_q] : 16'd0;
  assign all_terminated_o = ({6'd0, term_cnt_q} >= nproc);
endmodule
`default_nettype wire

>>> rtl/dplm_checker.sv
`default_nettype none
`include "demand_paging_lru_mmu_defines.svh"
module dplm_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       valid_o,
  input wire logic [2:0] status_o,
  input wire logic [5:0] frame_number_o,
  input wire logic [15:0] process_faults_o
);
  import dplm_pkg::*;
  // an accepted command always makes the unit busy
  `DPL_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  // a result beat ends the command
  `DPL_ASSERT_NXT(a_done_idle, clk_i, rst_ni, valid_o, !busy)
  // results only while busy
  `DPL_ASSERT_IMP(a_beat_busy, clk_i, rst_ni, valid_o, busy)
  // an invalid slot reports no frame and no faults
  `DPL_ASSERT_IMP(a_bad_proc, clk_i, rst_ni, valid_o && status_o == ST_BAD_PROC,
                  frame_number_o == 6'd0 && process_faults_o == 16'd0)
endmodule

bind demand_paging_lru_mmu dplm_checker u_dplm_checker (
  .clk_i, .rst_ni, .start, .busy, .valid_o, .status_o, .frame_number_o, .process_faults_o
);
`default_nettype wire

>>> test/testbench.sv
`default_nettype none
module testbench;
  import dplm_pkg::*;

  // register index that maps to no register, must be ignored
  localparam logic [1:0] CfgNone = 2'd3;
  localparam int MaxProcs  = 16;
  localparam int MaxPages  = 64;
  localparam int MaxFrames = 64;
  // longest command: full free scan plus lru over a full slot
  localparam int DrainCycles = 400;

  typedef struct {
    status_e     st;
    logic [5:0]  frame;
    logic [15:0] faults;
    logic        all_term;
  } xlate_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  command_i;
  logic [3:0]  process_slot_i;
  logic [6:0]  page_number_i;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [6:0]  cfg_data_i;
  logic        valid_o;
  logic [2:0]  status_o;
  logic [5:0]  frame_number_o;
  logic [15:0] process_faults_o;
  logic        all_terminated_o;

  demand_paging_lru_mmu i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .command_i        (command_i),
    .process_slot_i   (process_slot_i),
    .page_number_i    (page_number_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .valid_o          (valid_o),
    .status_o         (status_o),
    .frame_number_o   (frame_number_o),
    .process_faults_o (process_faults_o),
    .all_terminated_o (all_terminated_o)
  );

  // shadow of the mmu: page table, frame pool, counters and raw registers
  logic        pt_valid [MaxProcs*MaxPages];
  logic [5:0]  pt_frame [MaxProcs*MaxPages];
  logic [31:0] pt_stamp [MaxProcs*MaxPages];
  logic        frame_is_free [MaxFrames];
  logic [31:0] lru_clock;
  logic [15:0] slot_faults [MaxProcs];
  logic [6:0]  slot_limit [MaxProcs];
  logic [4:0]  term_count;
  logic [4:0]  reg_nproc;
  logic [6:0]  reg_npages;
  logic [6:0]  reg_nframes;

  xlate_t expected_q[$];
  int     errors;
  int     sender_idle_pct;

  initial clk_i = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // registers act as 1 when zero and saturate at the parameter maximum
  function automatic int clamp_reg(int v, int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  // one command applied to the shadow, giving the translation it should report
  function automatic xlate_t mmu_predict(logic [1:0] cmd, logic [3:0] slot,
                                         logic [6:0] page);
    int     nproc, npages, nframes, base, ent, best;
    bit     found, have;
    logic [31:0] best_stamp;
    xlate_t r;
    nproc   = clamp_reg(reg_nproc, MaxProcs);
    npages  = clamp_reg(reg_npages, MaxPages);
    nframes = clamp_reg(reg_nframes, MaxFrames);
    r.frame  = '0;
    r.faults = '0;
    if (slot >= nproc) begin
      r.st = ST_BAD_PROC;
      r.all_term = (term_count >= nproc);
      return r;
    end
    base = slot * npages;
    if (cmd == CMD_TERM) begin
      for (int i = 0; i < npages; i++) begin
        if (pt_valid[base+i]) begin
          frame_is_free[pt_frame[base+i]] = 1'b1;
          pt_valid[base+i] = 1'b0;
        end
      end
      if (term_count < 31) term_count++;
      r.st = ST_TERM;
    end else if (cmd == CMD_LIMIT) begin
      slot_limit[slot] = page;
      r.st = ST_LIMIT;
    end else if (cmd == CMD_BAD || page >= slot_limit[slot] || page >= npages) begin
      r.st = ST_BAD_PAGE;
    end else begin
      ent = base + page;
      if (pt_valid[ent]) begin
        pt_stamp[ent] = lru_clock;
        lru_clock++;
        r.st = ST_HIT;
        r.frame = pt_frame[ent];
      end else begin
        if (slot_faults[slot] != 16'hffff) slot_faults[slot]++;
        found = 1'b0;
        for (int i = 0; i < nframes && !found; i++) begin
          if (frame_is_free[i]) begin
            frame_is_free[i] = 1'b0;
            r.frame = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          // oldest stamp of this slot, lowest page on a tie
          have = 1'b0;
          best = 0;
          best_stamp = '0;
          for (int i = 0; i < npages; i++) begin
            if (pt_valid[base+i] && (!have || pt_stamp[base+i] < best_stamp)) begin
              have = 1'b1;
              best = base + i;
              best_stamp = pt_stamp[base+i];
            end
          end
          if (have) begin
            r.frame = pt_frame[best];
            pt_valid[best] = 1'b0;
            found = 1'b1;
          end
        end
        if (found) begin
          pt_frame[ent] = r.frame;
          pt_valid[ent] = 1'b1;
          pt_stamp[ent] = lru_clock;
          lru_clock++;
          r.st = ST_FAULT;
        end else begin
          r.st = ST_NO_VICT;
        end
      end
    end
    r.faults = slot_faults[slot];
    r.all_term = (term_count >= nproc);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // results come as one-cycle strobes and are checked against the oldest translation
  always @(posedge clk_i) begin
    xlate_t want;
    if (rst_ni && valid_o) begin
      if (expected_q.size() == 0) begin
        $display("unexpected result beat at %0t", $realtime);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (status_o !== want.st) report_mismatch("status", status_o, want.st);
        if (frame_number_o !== want.frame)
          report_mismatch("frame", frame_number_o, want.frame);
        if (process_faults_o !== want.faults)
          report_mismatch("faults", process_faults_o, want.faults);
        if (all_terminated_o !== want.all_term)
          report_mismatch("all_terminated", all_terminated_o, want.all_term);
      end
    end
  end

  // one command beat; start stays high so back-to-back beats need no gap
  task automatic issue_cmd(logic [1:0] cmd, logic [3:0] slot, logic [6:0] page);
    @(negedge clk_i);
    start = 1'b1;
    command_i = cmd;
    process_slot_i = slot;
    page_number_i = page;
    do @(posedge clk_i); while (busy);
    expected_q.push_back(mmu_predict(cmd, slot, page));
  endtask

  task automatic sender_idle(int n);
    repeat (n) begin
      @(negedge clk_i);
      start = 1'b0;
    end
  endtask

  task automatic maybe_idle();
    if ($urandom_range(99) < sender_idle_pct) sender_idle($urandom_range(6, 1));
  endtask

  // every command yields a result, so an empty queue means the unit is idle
  task automatic drain();
    sender_idle(1);
    while (expected_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    drain();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_NPROC:  reg_nproc = val[4:0];
      CFG_NPAGES: reg_npages = val;
      CFG_NFRAME: reg_nframes = val;
      default: ;
    endcase
  endtask

  // corner cases at the reset geometry and at tiny pools
  task automatic test_directed();
    issue_cmd(CMD_ACCESS, 4'd0, 7'd0);       // page beyond zero limit
    issue_cmd(CMD_LIMIT, 4'd0, 7'd64);
    issue_cmd(CMD_LIMIT, 4'd15, 7'd127);     // limit above the table
    issue_cmd(CMD_ACCESS, 4'd0, 7'd0);       // fault, frame 0
    issue_cmd(CMD_ACCESS, 4'd0, 7'd0);       // hit
    issue_cmd(CMD_ACCESS, 4'd0, 7'd63);
    issue_cmd(CMD_ACCESS, 4'd15, 7'd64);     // page past the table
    issue_cmd(CMD_ACCESS, 4'd15, 7'd127);
    issue_cmd(CMD_BAD, 4'd15, 7'd5);         // unknown command
    issue_cmd(CMD_TERM, 4'd0, 7'd0);
    issue_cmd(CMD_TERM, 4'd0, 7'd0);         // terminate again counts again
    write_reg(CFG_NPROC, 7'd2);
    issue_cmd(CMD_ACCESS, 4'd5, 7'd0);       // slot not in use
    issue_cmd(CMD_TERM, 4'd15, 7'd0);
    write_reg(CFG_NFRAME, 7'd0);             // zero acts as one frame
    write_reg(CFG_NPAGES, 7'd4);
    issue_cmd(CMD_LIMIT, 4'd1, 7'd4);
    issue_cmd(CMD_ACCESS, 4'd0, 7'd1);       // takes the only frame
    issue_cmd(CMD_ACCESS, 4'd1, 7'd2);       // pool empty, slot holds nothing
    issue_cmd(CMD_ACCESS, 4'd0, 7'd2);       // lru victim in own slot
    issue_cmd(CMD_ACCESS, 4'd0, 7'd1);
    write_reg(CfgNone, 7'd1);                // ignored index
    write_reg(CFG_NPROC, 7'd0);              // acts as one process
    issue_cmd(CMD_TERM, 4'd0, 7'd0);         // all terminated now
    write_reg(CFG_NPROC, 7'd127);            // masked then clamped to max
    write_reg(CFG_NPAGES, 7'd127);
    write_reg(CFG_NFRAME, 7'd127);
    issue_cmd(CMD_ACCESS, 4'd1, 7'd3);
  endtask

  // mostly well-formed access streams over a random geometry, some noise
  task automatic test_random_phase(int items);
    int nproc, npages, lim;
    logic [1:0] cmd;
    logic [3:0] slot;
    logic [6:0] page;
    case ($urandom_range(3))
      0: write_reg(CFG_NPROC, 7'($urandom_range(127)));
      default: write_reg(CFG_NPROC, 7'($urandom_range(16, 1)));
    endcase
    // small tables keep the scans short, now and then the full size
    write_reg(CFG_NPAGES, ($urandom_range(7) == 0) ? 7'd64 : 7'($urandom_range(8)));
    write_reg(CFG_NFRAME, ($urandom_range(7) == 0) ? 7'd127 : 7'($urandom_range(12)));
    nproc  = clamp_reg(reg_nproc, MaxProcs);
    npages = clamp_reg(reg_npages, MaxPages);
    for (int s = 0; s < nproc; s++) begin
      lim = ($urandom_range(3) == 0) ? $urandom_range(npages + 2) : npages;
      issue_cmd(CMD_LIMIT, 4'(s), 7'(lim));
      maybe_idle();
    end
    for (int n = 0; n < items; n++) begin
      slot = 4'($urandom_range(nproc - 1));
      page = 7'($urandom_range(npages - 1));
      cmd  = CMD_ACCESS;
      case ($urandom_range(99)) inside
        [0:7]:   cmd = CMD_TERM;
        [8:11]:  page = 7'($urandom_range(npages + 2));
        [12:14]: cmd = CMD_LIMIT;
        [15:17]: cmd = CMD_BAD;
        [18:21]: slot = 4'($urandom_range(15));
        [22:24]: page = 7'($urandom_range(127));
        default: ;
      endcase
      if (cmd == CMD_LIMIT) page = 7'($urandom_range(npages + 1));
      issue_cmd(cmd, slot, page);
      maybe_idle();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    command_i = '0;
    process_slot_i = '0;
    page_number_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    errors = 0;
    sender_idle_pct = 0;
    reg_nproc = 5'd16;
    reg_npages = 7'd64;
    reg_nframes = 7'd64;
    lru_clock = '0;
    term_count = '0;
    foreach (pt_valid[i]) pt_valid[i] = 1'b0;
    foreach (frame_is_free[i]) frame_is_free[i] = 1'b1;
    foreach (slot_faults[i]) slot_faults[i] = '0;
    foreach (slot_limit[i]) slot_limit[i] = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    // sender gaps at 20 then 68 percent, then none
    for (int ph = 0; ph < 12; ph++) begin
      sender_idle_pct = (ph < 4) ? 20 : (ph < 8) ? 68 : 0;
      test_random_phase(160);
      if (ph == 5) drain();
    end

    drain();
    repeat (DrainCycles) @(negedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire

>>> demand_paging_lru_mmu.f
+incdir+rtl
rtl/dplm_pkg.sv
rtl/dplm_ram.sv
rtl/dplm_cmp.sv
rtl/demand_paging_lru_mmu.sv
rtl/dplm_checker.sv
test/testbench.sv
